// ===== src/pitp_pkg.sv =====
// Shared types and constants for the projected point-in-triangle block.
package pitp_pkg;

  localparam int DEF_COORD_BITS = 32;
  localparam int PORT_BITS      = 32;
  localparam int NUM_VERTS      = 3;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_NORMAL = 2'd1;
  localparam logic [1:0] REQ_TEST   = 2'd2;

  // Projection codes chosen from the dominant normal component.
  localparam logic [1:0] AXIS_X = 2'd0;  // y runs along, z compared
  localparam logic [1:0] AXIS_Y = 2'd1;  // z runs along, x compared
  localparam logic [1:0] AXIS_Z = 2'd2;  // y runs along, x compared

  // Status from the edge sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } seq_stat_t;

endpackage

// ===== src/pitp_mul.sv =====
// Shared signed multiplier with a registered product.
module pitp_mul import pitp_pkg::*; #(
  parameter int OP_BITS = DEF_COORD_BITS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [OP_BITS-1:0]   op_a,
  input  logic signed [OP_BITS-1:0]   op_b,
  output logic signed [2*OP_BITS-1:0] prod
);

  logic signed [2*OP_BITS-1:0] prod_r;
  logic signed [2*OP_BITS-1:0] prod_nxt;

  always_comb begin
    prod_nxt = prod_r;
    if (en) begin
      prod_nxt = (2*OP_BITS)'(op_a) * (2*OP_BITS)'(op_b);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== src/pitp_seq.sv =====
// Edge walker: tests the three projected edges one after another on the shared multiplier.
module pitp_seq import pitp_pkg::*; #(
  parameter int CW = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_free,
  input  logic signed [CW-1:0] run_in [NUM_VERTS],
  input  logic signed [CW-1:0] cmp_in [NUM_VERTS],
  input  logic signed [CW-1:0] pt_run,
  input  logic signed [CW-1:0] pt_cmp,
  output seq_stat_t            stat
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_MN   = 3'd2;
  localparam logic [2:0] ST_ML   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] LAST_EDGE = 2'(NUM_VERTS - 1);

  logic [2:0] state_r, state_nxt;
  logic [1:0] edge_r, edge_nxt;
  logic       inside_r, inside_nxt;

  // Slot 0 always holds the current vertex and slot 2 the previous one;
  // the rings rotate once per edge.
  logic signed [CW-1:0] run_r [NUM_VERTS];
  logic signed [CW-1:0] cmp_r [NUM_VERTS];
  logic signed [CW-1:0] prun_r, pcmp_r;

  logic signed [DW-1:0] da_r, db_r, dl_r, dd_r;
  logic signed [PW-1:0] n_r;

  logic                 straddle;
  logic                 advance;
  logic                 below;
  logic                 dpos;
  logic                 mul_en;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;

  pitp_mul #(.OP_BITS(DW)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign straddle = ((run_r[0] <= prun_r) && (prun_r < run_r[2])) ||
                    ((run_r[2] <= prun_r) && (prun_r < run_r[0]));
  assign dpos     = (dd_r > 0);
  // prod holds l = (point_cmp - cx) * d here, n_r holds (point_run - ca) * (px - cx).
  assign below    = dpos ? (prod < n_r) : (n_r < prod);

  always_comb begin
    mul_en = 1'b0;
    op_a   = da_r;
    op_b   = db_r;
    unique case (state_r)
      ST_MN: begin
        mul_en = 1'b1;
      end
      ST_ML: begin
        mul_en = 1'b1;
        op_a   = dl_r;
        op_b   = dd_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    edge_nxt   = edge_r;
    inside_nxt = inside_r;
    advance    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_CHK;
          edge_nxt   = '0;
          inside_nxt = 1'b0;
        end
      end
      ST_CHK: begin
        if (straddle) begin
          state_nxt = ST_MN;
        end else begin
          advance = 1'b1;
        end
      end
      ST_MN: begin
        state_nxt = ST_ML;
      end
      ST_ML: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        advance = 1'b1;
        if (below) begin
          inside_nxt = ~inside_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (advance) begin
      if (edge_r == LAST_EDGE) begin
        state_nxt = ST_DONE;
      end else begin
        state_nxt = ST_CHK;
        edge_nxt  = edge_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      edge_r   <= '0;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      edge_r   <= edge_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      run_r  <= run_in;
      cmp_r  <= cmp_in;
      prun_r <= pt_run;
      pcmp_r <= pt_cmp;
    end else if (advance) begin
      run_r[0] <= run_r[1];
      run_r[1] <= run_r[2];
      run_r[2] <= run_r[0];
      cmp_r[0] <= cmp_r[1];
      cmp_r[1] <= cmp_r[2];
      cmp_r[2] <= cmp_r[0];
    end
    if (state_r == ST_CHK) begin
      da_r <= DW'(prun_r) - DW'(run_r[0]);
      db_r <= DW'(cmp_r[2]) - DW'(cmp_r[0]);
      dl_r <= DW'(pcmp_r) - DW'(cmp_r[0]);
      dd_r <= DW'(run_r[2]) - DW'(run_r[0]);
    end
    if (state_r == ST_ML) begin
      n_r <= prod;
    end
  end

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE) && out_free;
  assign stat.hit  = inside_r;

endmodule

// ===== src/point_in_triangle_projected.sv =====
// Top level of the projected point-in-triangle block: vertex store, projection choice, handshakes.
// Loads (vertex or normal) are written when accepted and give no result. A test transaction
// gives one result: 1 when the point lies inside the triangle projected onto the plane picked
// by the largest normal component. A test occupies the block through these steps: the accept,
// a check of each edge, for each edge that straddles the point two products on the single
// shared multiplier and a compare (under the half-open rule either no side or exactly two
// sides straddle), and the handoff of the result to the output register, which waits while an
// earlier result still waits there. in_stall is high from the accepting edge until that handoff.
// The result register holds its value until taken, and a new transaction may be accepted
// while it waits. Vertices and the normal must be loaded before the first test.
module point_in_triangle_projected import pitp_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [1:0]           in_vertex_slot,
  input  logic signed [PORT_BITS-1:0] in_value_x,
  input  logic signed [PORT_BITS-1:0] in_value_y,
  input  logic signed [PORT_BITS-1:0] in_value_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_inside_res
);

  localparam int CW = (COORD_BITS < PORT_BITS) ? COORD_BITS : PORT_BITS;

  logic signed [CW-1:0] vx_r [NUM_VERTS];
  logic signed [CW-1:0] vy_r [NUM_VERTS];
  logic signed [CW-1:0] vz_r [NUM_VERTS];
  logic [1:0]           axis_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 inside_r;

  logic signed [CW-1:0] px, py, pz;
  logic [CW-1:0]        ax, ay, az;
  logic [1:0]           axis_new;
  logic                 accept;
  logic                 out_free;
  logic                 run_is_z, cmp_is_z;
  logic signed [CW-1:0] run_v [NUM_VERTS];
  logic signed [CW-1:0] cmp_v [NUM_VERTS];
  logic signed [CW-1:0] pt_run, pt_cmp;
  seq_stat_t            stat;

  // Coordinates are taken from the low CW bits of each port, read as signed values.
  assign px = in_value_x[CW-1:0];
  assign py = in_value_y[CW-1:0];
  assign pz = in_value_z[CW-1:0];

  assign accept   = in_valid && !in_stall;
  assign in_stall = stat.busy;
  assign out_free = !out_valid_r || !out_stall;

  // The most negative value negates to itself, which reads correctly as unsigned.
  assign ax = (px < 0) ? CW'(-px) : CW'(px);
  assign ay = (py < 0) ? CW'(-py) : CW'(py);
  assign az = (pz < 0) ? CW'(-pz) : CW'(pz);

  always_comb begin
    if (az > ay) begin
      axis_new = (az > ax) ? AXIS_Z : AXIS_X;
    end else if (ay > ax) begin
      axis_new = AXIS_Y;
    end else begin
      axis_new = AXIS_X;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_VERTEX && in_vertex_slot < 2'(NUM_VERTS)) begin
      vx_r[in_vertex_slot] <= px;
      vy_r[in_vertex_slot] <= py;
      vz_r[in_vertex_slot] <= pz;
    end
    if (accept && in_req_type == REQ_NORMAL) begin
      axis_r <= axis_new;
    end
    if (stat.done) begin
      inside_r <= stat.hit;
    end
  end

  assign run_is_z = (axis_r == AXIS_Y);
  assign cmp_is_z = (axis_r == AXIS_X);

  always_comb begin
    for (int i = 0; i < NUM_VERTS; i++) begin
      run_v[i] = run_is_z ? vz_r[i] : vy_r[i];
      cmp_v[i] = cmp_is_z ? vz_r[i] : vx_r[i];
    end
  end

  assign pt_run = run_is_z ? pz : py;
  assign pt_cmp = cmp_is_z ? pz : px;

  pitp_seq #(.CW(CW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && in_req_type == REQ_TEST),
    .out_free (out_free),
    .run_in   (run_v),
    .cmp_in   (cmp_v),
    .pt_run   (pt_run),
    .pt_cmp   (pt_cmp),
    .stat     (stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

endmodule

// ===== verif/pitp_checker.sv =====
// Checker for the projected point-in-triangle block: shadow stores, predicted flags, comparison.
`timescale 1ns / 100ps

module pitp_checker import pitp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [1:0]                  in_vertex_slot,
  input  logic signed [PORT_BITS-1:0] in_value_x,
  input  logic signed [PORT_BITS-1:0] in_value_y,
  input  logic signed [PORT_BITS-1:0] in_value_z,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_inside_res,
  output int                          fail_count,
  output int                          results_due
);

  // Shadow copies of the vertex and normal stores, widened so differences never wrap.
  logic signed [63:0] vtx [3*NUM_VERTS];
  logic signed [63:0] nrm [3];
  logic               inside_due [$];
  int                 result_idx;

  // Even-odd crossing test on the plane picked by the dominant normal component.
  function automatic logic predict_inside(input logic signed [31:0] qx, qy, qz);
    logic signed [63:0]  pt [3];
    logic signed [63:0]  ax, ay, az, ca, pa, cx, px, d;
    logic signed [127:0] cross_n, cross_l;
    logic [1:0]          axis;
    logic                flag;
    int                  run_i, cmp_i, prev, i;
    pt[0] = 64'(qx);
    pt[1] = 64'(qy);
    pt[2] = 64'(qz);
    ax = (nrm[0] < 0) ? -nrm[0] : nrm[0];
    ay = (nrm[1] < 0) ? -nrm[1] : nrm[1];
    az = (nrm[2] < 0) ? -nrm[2] : nrm[2];
    if (az > ay) axis = (az > ax) ? AXIS_Z : AXIS_X;
    else if (ay > ax) axis = AXIS_Y;
    else axis = AXIS_X;
    case (axis)
      AXIS_Z: begin
        run_i = 1;
        cmp_i = 0;
      end
      AXIS_Y: begin
        run_i = 2;
        cmp_i = 0;
      end
      default: begin
        run_i = 1;
        cmp_i = 2;
      end
    endcase
    flag = 1'b0;
    prev = 2;
    for (i = 0; i < NUM_VERTS; i++) begin
      ca = vtx[i*3 + run_i];
      pa = vtx[prev*3 + run_i];
      // Half-open straddle: the lower end counts, the upper end does not.
      if ((ca <= pt[run_i] && pt[run_i] < pa) || (pa <= pt[run_i] && pt[run_i] < ca)) begin
        cx = vtx[i*3 + cmp_i];
        px = vtx[prev*3 + cmp_i];
        d  = pa - ca;
        // The crossing comparison is cross-multiplied, so the sign of d flips it.
        cross_n = 128'(pt[run_i] - ca) * 128'(px - cx);
        cross_l = 128'(pt[cmp_i] - cx) * 128'(d);
        if (d > 0 ? cross_l < cross_n : cross_n < cross_l) flag = ~flag;
      end
      prev = i;
    end
    return flag;
  endfunction

  task automatic flag_error(input string what, input logic want, input logic got);
    if (fail_count < 10)
      $display("%0t: result %0d %s: expected %b, actual %b", $time, result_idx, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    logic want;
    int   base;
    if (!rst_n) begin
      inside_due.delete();
      result_idx  = 0;
      results_due <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_VERTEX: begin
            if (in_vertex_slot < NUM_VERTS) begin
              base = int'(in_vertex_slot) * 3;
              vtx[base]     = 64'(in_value_x);
              vtx[base + 1] = 64'(in_value_y);
              vtx[base + 2] = 64'(in_value_z);
            end
          end
          REQ_NORMAL: begin
            nrm[0] = 64'(in_value_x);
            nrm[1] = 64'(in_value_y);
            nrm[2] = 64'(in_value_z);
          end
          REQ_TEST: inside_due.push_back(predict_inside(in_value_x, in_value_y, in_value_z));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (inside_due.size() == 0) begin
          flag_error("with no transaction pending", 1'bx, out_inside_res);
        end else begin
          want = inside_due.pop_front();
          if (want !== out_inside_res) flag_error("inside_res", want, out_inside_res);
        end
        result_idx++;
      end
      results_due <= inside_due.size();
    end
  end

endmodule

// ===== verif/tb_point_in_triangle_projected.sv =====
// Testbench top for the projected point-in-triangle block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_point_in_triangle_projected;
  import pitp_pkg::*;

  localparam int          TARGET_ITEMS = 450;
  localparam int          CALM_AFTER   = 400;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 40;
  localparam logic [1:0]  REQ_NONE     = 2'd3;
  localparam logic [31:0] C_MIN        = 32'h8000_0000;
  localparam logic [31:0] C_MAX        = 32'h7FFF_FFFF;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type    = REQ_VERTEX;
  logic [1:0]  in_vertex_slot = 2'd0;
  logic [31:0] in_value_x     = '0;
  logic [31:0] in_value_y     = '0;
  logic [31:0] in_value_z     = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_inside_res;

  int     fail_count;
  int     results_due;
  int     real_items  = 0;
  int     idle_cycles = 0;
  int     stall_left  = 0;
  logic   calm        = 1'b0;
  longint tri_c [3][3];

  point_in_triangle_projected u_dut (.*);

  pitp_checker u_check (.*);

  always #6 clk = ~clk;

  // Result side: random stall bursts until the closing stretch of the run.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("point_in_triangle_projected: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_coord(input int scale);
    case (scale)
      0:       return $urandom_range(0, 16) - 32'd8;
      1:       return $urandom_range(0, 2000) - 32'd1000;
      2:       return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  // A coordinate near the loaded triangle: a vertex value, inside its span, or anywhere.
  function automatic logic [31:0] near_triangle(input int a);
    longint lo, hi;
    int     k;
    case ($urandom_range(0, 7))
      0, 1:    return 32'(tri_c[$urandom_range(0, 2)][a]);
      2:       return pick_coord($urandom_range(0, 3));
      default: begin
        lo = tri_c[0][a];
        hi = lo;
        for (k = 1; k < 3; k++) begin
          if (tri_c[k][a] < lo) lo = tri_c[k][a];
          if (tri_c[k][a] > hi) hi = tri_c[k][a];
        end
        return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
      end
    endcase
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [1:0] slot,
                              input logic [31:0] x, y, z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_vertex_slot <= slot;
    in_value_x     <= x;
    in_value_y     <= y;
    in_value_z     <= z;
    do @(posedge clk); while (in_stall);
    if (req == REQ_TEST || req == REQ_NORMAL || (req == REQ_VERTEX && slot < NUM_VERTS))
      real_items++;
  endtask

  task automatic load_vertex(input int slot, input logic [31:0] x, y, z);
    tri_c[slot][0] = longint'($signed(x));
    tri_c[slot][1] = longint'($signed(y));
    tri_c[slot][2] = longint'($signed(z));
    send_request(REQ_VERTEX, 2'(slot), x, y, z);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // One well-formed sequence: a fresh triangle, a normal, then several test points.
  task automatic run_triangle_set();
    logic [31:0] nv [3];
    int          scale, first, n_pts, k, s;
    scale = $urandom_range(0, 3);
    first = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      s = (first + k) % 3;
      load_vertex(s, pick_coord(scale), pick_coord(scale), pick_coord(scale));
    end
    for (k = 0; k < 3; k++) nv[k] = pick_coord($urandom_range(0, 3));
    // Equal magnitudes exercise the tie rules of the axis choice.
    if ($urandom_range(0, 3) == 0) begin
      s = $urandom_range(0, 2);
      nv[(s + 1) % 3] = $urandom_range(0, 1) ? nv[s] : -nv[s];
    end
    send_request(REQ_NORMAL, 2'($urandom_range(0, 3)), nv[0], nv[1], nv[2]);
    n_pts = $urandom_range(2, 6);
    for (k = 0; k < n_pts; k++)
      send_request(REQ_TEST, 2'($urandom_range(0, 3)),
                   near_triangle(0), near_triangle(1), near_triangle(2));
  endtask

  task automatic run_noise_item();
    logic [1:0] req, slot;
    req  = 2'($urandom_range(0, 3));
    slot = 2'($urandom_range(0, 3));
    if (req == REQ_VERTEX && slot < NUM_VERTS)
      load_vertex(int'(slot), $urandom, $urandom, $urandom);
    else
      send_request(req, slot, $urandom, $urandom, $urandom);
  endtask

  initial begin : stimulus
    logic mid_drained;
    mid_drained = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Right triangle in the y-z plane; the normal favors x with z beating y.
    load_vertex(0, 32'd0, 32'd0, 32'd0);
    load_vertex(1, 32'd0, 32'd100, 32'd0);
    load_vertex(2, 32'd0, 32'd0, 32'd100);
    send_request(REQ_NORMAL, 2'd0, 32'd5, 32'd1, -32'sd2);
    send_request(REQ_TEST, 2'd0, 32'd0, 32'd10, 32'd10);
    send_request(REQ_TEST, 2'd1, 32'd0, 32'd0, 32'd0);
    send_request(REQ_TEST, 2'd2, 32'd0, 32'd50, 32'd50);
    send_request(REQ_TEST, 2'd3, 32'd0, 32'd100, 32'd0);
    // A load to the fourth slot and the unused request code change nothing.
    send_request(REQ_VERTEX, 2'd3, 32'd7, 32'd7, 32'd7);
    send_request(REQ_NONE, 2'd0, 32'd9, 32'd9, 32'd9);
    send_request(REQ_TEST, 2'd0, 32'd0, 32'd10, 32'd10);

    // A tilted triangle seen through every projection, ties included.
    load_vertex(1, 32'd60, 32'd100, -32'sd20);
    load_vertex(2, -32'sd40, 32'd30, 32'd90);
    send_request(REQ_NORMAL, 2'd0, 32'd3, 32'd3, 32'd3);
    send_request(REQ_TEST, 2'd0, 32'd10, 32'd40, 32'd30);
    send_request(REQ_NORMAL, 2'd0, 32'd1, 32'd3, -32'sd3);
    send_request(REQ_TEST, 2'd0, 32'd10, 32'd40, 32'd30);
    send_request(REQ_NORMAL, 2'd0, -32'sd1, 32'd2, -32'sd9);
    send_request(REQ_TEST, 2'd0, 32'd10, 32'd40, 32'd30);

    // Full-scale coordinates; two vertices share y, so one edge is degenerate.
    load_vertex(0, C_MIN, C_MIN, C_MAX);
    load_vertex(1, C_MAX, C_MAX, C_MIN);
    load_vertex(2, C_MIN, C_MAX, C_MIN);
    send_request(REQ_NORMAL, 2'd0, C_MIN, C_MAX, C_MIN);
    send_request(REQ_TEST, 2'd0, C_MAX, 32'd0, 32'd0);
    send_request(REQ_TEST, 2'd0, C_MIN, C_MIN, C_MIN);
    send_request(REQ_TEST, 2'd0, 32'd0, C_MAX, C_MAX);

    hold_until_drained();

    while (real_items < TARGET_ITEMS) begin
      if (real_items >= CALM_AFTER && !calm) calm <= 1'b1;
      if (real_items >= TARGET_ITEMS / 2 && !mid_drained) begin
        hold_until_drained();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 19) < 17) run_triangle_set();
      else run_noise_item();
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("point_in_triangle_projected: match");
    end else begin
      $display("point_in_triangle_projected: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pitp_pkg.sv
src/pitp_mul.sv
src/pitp_seq.sv
src/point_in_triangle_projected.sv
verif/pitp_checker.sv
verif/tb_point_in_triangle_projected.sv
